// ===== hdl/framebuffer_blend_fill_engine_core_macros.svh =====
// assertion helpers used by the engine's back module
`ifndef FRAMEBUFFER_BLEND_FILL_ENGINE_CORE_MACROS_SVH
`define FRAMEBUFFER_BLEND_FILL_ENGINE_CORE_MACROS_SVH

// cond in a cycle implies prop in the same cycle
`define FBF_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// cond in a cycle implies prop in the next cycle
`define FBF_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== hdl/fbf_pkg.sv =====
package fbf_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int YW         = $clog2(MAX_HEIGHT);
    localparam int AW         = $clog2(DEPTH);

    // signed coordinate width used for clipping and circle offsets
    localparam int CW  = 14;
    localparam int SQW = 2 * CW - 1;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int PIX_W     = 24;

    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = QPW + 1;

    localparam logic [PIX_W-1:0] WHITE     = 24'hFFFFFF;
    localparam logic [8:0]       ALPHA_MAX = 9'd256;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 1'b1;

    localparam logic [2:0] CMD_BLEND_PIXEL  = 3'd0;
    localparam logic [2:0] CMD_BLEND_SQUARE = 3'd1;
    localparam logic [2:0] CMD_BLEND_CIRCLE = 3'd2;
    localparam logic [2:0] CMD_FILL         = 3'd3;
    localparam logic [2:0] CMD_READ_PIXEL   = 3'd4;

    localparam logic [1:0] OP_NOP   = 2'd0;
    localparam logic [1:0] OP_BLEND = 2'd1;
    localparam logic [1:0] OP_FILL  = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [11:0] x_pos;
        logic signed [11:0] y_pos;
        logic [9:0]         size;
        logic [7:0]         red_in;
        logic [7:0]         green_in;
        logic [7:0]         blue_in;
        logic [8:0]         alpha;
    } req_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       done_res;
    } rsp_t;

    // classified request as handed from front to back
    typedef struct packed {
        logic [1:0]           op;
        logic                 empty;
        logic                 circle;
        logic [XW-1:0]        xs;
        logic [XW-1:0]        xl;
        logic [YW-1:0]        ys;
        logic [YW-1:0]        yl;
        logic signed [CW-1:0] dx0;
        logic signed [CW-1:0] dy0;
        logic [SQW-1:0]       dx0sq;
        logic [SQW-1:0]       dy0sq;
        logic [SQW-1:0]       szsq;
        logic [PIX_W-1:0]     color;
        logic [8:0]           alpha;
    } desc_t;

    typedef struct packed {
        logic           empty;
        logic [QCW-1:0] count;
    } q_status_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

// ===== hdl/fbf_queue.sv =====
module fbf_queue
    import fbf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  desc_t     push_desc,
    input  logic      pop,
    output desc_t     pop_desc,
    output q_status_t status
);

    desc_t          entry_reg [QDEPTH];
    logic [QPW-1:0] wr_ptr_reg;
    logic [QPW-1:0] wr_ptr_next;
    logic [QPW-1:0] rd_ptr_reg;
    logic [QPW-1:0] rd_ptr_next;
    logic [QCW-1:0] count_reg;
    logic [QCW-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    assign pop_desc     = entry_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;

endmodule

// ===== hdl/fbf_front.sv =====
module fbf_front
    import fbf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  req_t                 req,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data,
    input  q_status_t            q_status,
    output logic                 full,
    output logic                 push,
    output desc_t                push_desc
);

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] width_next;
    logic [CFG_W-1:0] height_reg;
    logic [CFG_W-1:0] height_next;

    logic  s1_valid_reg;
    logic  s2_valid_reg;
    desc_t s1_desc_reg;
    desc_t s1_desc_next;
    logic [9:0] s1_size_reg;
    desc_t s2_desc_reg;
    desc_t s2_desc_next;

    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
    logic signed [CW-1:0] sz_s;
    logic signed [CW-1:0] w_lim;
    logic signed [CW-1:0] h_lim;
    logic signed [CW-1:0] span;
    logic signed [CW-1:0] xa;
    logic signed [CW-1:0] xb;
    logic signed [CW-1:0] ya;
    logic signed [CW-1:0] yb;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] xe;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] ye;
    logic signed [CW-1:0] xl_full;
    logic signed [CW-1:0] yl_full;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic [1:0]           op;
    logic                 circle;
    logic                 fill;

    logic signed [2*CW-1:0] dx_prod;
    logic signed [2*CW-1:0] dy_prod;
    logic [19:0]            sz_prod;
    logic [QCW:0]           occupancy;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_ACTIVE_WIDTH:  width_next  = wr_data;
                REG_ACTIVE_HEIGHT: height_next = wr_data;
                default: ;
            endcase
        end
    end

    // classify the request and clip its box to the canvas
    always_comb
    begin
        x0    = CW'($signed(req.x_pos));
        y0    = CW'($signed(req.y_pos));
        sz_s  = $signed(CW'(req.size));
        w_lim = (CW'(width_reg) > CW'(MAX_WIDTH)) ? $signed(CW'(MAX_WIDTH))
                                                  : $signed(CW'(width_reg));
        h_lim = (CW'(height_reg) > CW'(MAX_HEIGHT)) ? $signed(CW'(MAX_HEIGHT))
                                                    : $signed(CW'(height_reg));
        op     = OP_NOP;
        circle = 1'b0;
        fill   = 1'b0;
        span   = CW'(1);
        unique case (req.cmd)
            CMD_BLEND_PIXEL:  op = OP_BLEND;
            CMD_BLEND_SQUARE:
            begin
                op   = OP_BLEND;
                span = sz_s;
            end
            CMD_BLEND_CIRCLE:
            begin
                op     = OP_BLEND;
                circle = 1'b1;
                span   = sz_s <<< 1;
            end
            CMD_FILL:
            begin
                op   = OP_FILL;
                fill = 1'b1;
            end
            CMD_READ_PIXEL:   op = OP_READ;
            default:          op = OP_NOP;
        endcase

        xa = fill ? '0 : x0;
        xb = fill ? w_lim : x0 + span;
        ya = fill ? '0 : y0;
        yb = fill ? h_lim : y0 + span;
        xs = (xa < 0) ? '0 : xa;
        ys = (ya < 0) ? '0 : ya;
        xe = (xb > w_lim) ? w_lim : xb;
        ye = (yb > h_lim) ? h_lim : yb;
        xl_full = xe - CW'(1);
        yl_full = ye - CW'(1);
        cx = x0 + sz_s;
        cy = y0 + sz_s;

        s1_desc_next        = '0;
        s1_desc_next.op     = op;
        s1_desc_next.empty  = (xs >= xe) || (ys >= ye);
        s1_desc_next.circle = circle;
        s1_desc_next.xs     = xs[XW-1:0];
        s1_desc_next.xl     = xl_full[XW-1:0];
        s1_desc_next.ys     = ys[YW-1:0];
        s1_desc_next.yl     = yl_full[YW-1:0];
        s1_desc_next.dx0    = xs - cx;
        s1_desc_next.dy0    = ys - cy;
        s1_desc_next.color  = {req.red_in, req.green_in, req.blue_in};
        s1_desc_next.alpha  = (req.alpha > ALPHA_MAX) ? ALPHA_MAX : req.alpha;
    end

    // squares of the starting offsets and of the radius
    always_comb
    begin
        dx_prod = $signed(s1_desc_reg.dx0) * $signed(s1_desc_reg.dx0);
        dy_prod = $signed(s1_desc_reg.dy0) * $signed(s1_desc_reg.dy0);
        sz_prod = s1_size_reg * s1_size_reg;
        s2_desc_next       = s1_desc_reg;
        s2_desc_next.dx0sq = dx_prod[SQW-1:0];
        s2_desc_next.dy0sq = dy_prod[SQW-1:0];
        s2_desc_next.szsq  = SQW'(sz_prod);
    end

    // requests in both stages count against the queue so nothing ever stalls
    assign occupancy = (QCW+1)'(q_status.count) + (QCW+1)'(s1_valid_reg)
                     + (QCW+1)'(s2_valid_reg);
    assign full      = (occupancy >= (QCW+1)'(QDEPTH));
    assign push      = s2_valid_reg;
    assign push_desc = s2_desc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= CFG_W'(256);
            height_reg   <= CFG_W'(256);
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_desc_reg <= s1_desc_next;
            s1_size_reg <= req.size;
        end
        s2_desc_reg <= s2_desc_next;
    end

endmodule

// ===== hdl/fbf_back.sv =====
`include "framebuffer_blend_fill_engine_core_macros.svh"

module fbf_back
    import fbf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  q_status_t    q_status,
    input  desc_t        pop_desc,
    output logic         pop,
    output rsp_t         rsp,
    output logic         done,
    output back_status_t status
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SETUP  = 3'd2;
    localparam logic [2:0] ST_RDWAIT = 3'd3;
    localparam logic [2:0] ST_RUN    = 3'd4;
    localparam logic [2:0] ST_DRAIN  = 3'd5;

    logic [PIX_W-1:0] frame_mem [DEPTH];

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [AW-1:0]        clr_addr_reg;
    logic [AW-1:0]        clr_addr_next;
    desc_t                cur_reg;
    desc_t                cur_next;
    logic [XW-1:0]        x_reg;
    logic [XW-1:0]        x_next;
    logic [YW-1:0]        y_reg;
    logic [YW-1:0]        y_next;
    logic signed [CW-1:0] dx_reg;
    logic signed [CW-1:0] dx_next;
    logic signed [CW-1:0] dy_reg;
    logic signed [CW-1:0] dy_next;
    logic [SQW-1:0]       dx2_reg;
    logic [SQW-1:0]       dx2_next;
    logic [SQW-1:0]       dy2_reg;
    logic [SQW-1:0]       dy2_next;
    logic                 wb_valid_reg;
    logic                 wb_valid_next;
    logic [AW-1:0]        wb_addr_reg;
    logic [AW-1:0]        wb_addr_next;
    logic [PIX_W-1:0]     rd_data_reg;
    rsp_t                 rsp_reg;
    rsp_t                 rsp_next;
    logic                 done_reg;
    logic                 done_next;

    logic [AW-1:0]    pix_addr;
    logic             in_disc;
    logic             x_last;
    logic             y_last;
    logic [PIX_W-1:0] blended;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [PIX_W-1:0] mem_wdata;

    // dst + floor((src - dst) * a / 256), same as the two-product form
    function automatic logic [7:0] mix8(input logic [7:0] s, input logic [7:0] d,
                                        input logic [8:0] a);
        logic signed [8:0]  diff;
        logic signed [18:0] prod;
        logic signed [10:0] sum;
        diff = $signed({1'b0, s}) - $signed({1'b0, d});
        prod = diff * $signed({1'b0, a});
        sum  = 11'(prod >>> 8) + $signed({3'b0, d});
        return sum[7:0];
    endfunction

    assign pix_addr = AW'(y_reg) * AW'(MAX_WIDTH) + AW'(x_reg);
    assign in_disc  = !cur_reg.circle
                   || (({1'b0, dx2_reg} + {1'b0, dy2_reg}) < {1'b0, cur_reg.szsq});
    assign x_last   = (x_reg == cur_reg.xl);
    assign y_last   = (y_reg == cur_reg.yl);
    assign blended  = {mix8(cur_reg.color[23:16], rd_data_reg[23:16], cur_reg.alpha),
                       mix8(cur_reg.color[15:8], rd_data_reg[15:8], cur_reg.alpha),
                       mix8(cur_reg.color[7:0], rd_data_reg[7:0], cur_reg.alpha)};
    assign pop      = (state_reg == ST_IDLE) && !q_status.empty;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wb_addr_reg;
        mem_wdata = blended;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = WHITE;
        end
        else if ((state_reg == ST_RUN) && (cur_reg.op == OP_FILL))
        begin
            mem_we    = 1'b1;
            mem_waddr = pix_addr;
            mem_wdata = cur_reg.color;
        end
        else if (wb_valid_reg)
        begin
            mem_we = 1'b1;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        cur_next      = cur_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        dx2_next      = dx2_reg;
        dy2_next      = dy2_reg;
        wb_valid_next = 1'b0;
        wb_addr_next  = pix_addr;
        rsp_next      = '0;
        rsp_next.done_res = 1'b1;
        done_next     = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (pop)
                begin
                    cur_next   = pop_desc;
                    x_next     = pop_desc.xs;
                    y_next     = pop_desc.ys;
                    dx_next    = pop_desc.dx0;
                    dy_next    = pop_desc.dy0;
                    dx2_next   = pop_desc.dx0sq;
                    dy2_next   = pop_desc.dy0sq;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                // the read port already looks at the first pixel here
                if ((cur_reg.op == OP_NOP) || cur_reg.empty)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (cur_reg.op == OP_READ)
                begin
                    state_next = ST_RDWAIT;
                end
                else
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RDWAIT:
            begin
                rsp_next.red_out   = rd_data_reg[23:16];
                rsp_next.green_out = rd_data_reg[15:8];
                rsp_next.blue_out  = rd_data_reg[7:0];
                done_next          = 1'b1;
                state_next         = ST_IDLE;
            end
            ST_RUN:
            begin
                wb_valid_next = (cur_reg.op == OP_BLEND) && in_disc;
                if (x_last)
                begin
                    x_next   = cur_reg.xs;
                    dx_next  = cur_reg.dx0;
                    dx2_next = cur_reg.dx0sq;
                    y_next   = y_reg + 1'b1;
                    dy_next  = dy_reg + CW'(1);
                    dy2_next = dy2_reg + SQW'($signed({dy_reg, 1'b1}));
                    if (y_last)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    x_next   = x_reg + 1'b1;
                    dx_next  = dx_reg + CW'(1);
                    dx2_next = dx2_reg + SQW'($signed({dx_reg, 1'b1}));
                end
            end
            ST_DRAIN:
            begin
                // last write-back lands at the end of this cycle
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            wb_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            wb_valid_reg <= wb_valid_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        dx2_reg     <= dx2_next;
        dy2_reg     <= dy2_next;
        wb_addr_reg <= wb_addr_next;
        rsp_reg     <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= frame_mem[pix_addr];
    end

    assign rsp             = rsp_reg;
    assign done            = done_reg;
    assign status.clearing = (state_reg == ST_CLEAR);

    `FBF_ASSERT_NOW(a_no_done_in_clear, clk, rst_n, state_reg == ST_CLEAR,
                    !done_reg, "result during clear pass")
    `FBF_ASSERT_NOW(a_wb_only_in_run, clk, rst_n, wb_valid_reg,
                    state_reg == ST_RUN || state_reg == ST_DRAIN, "write-back outside a shape")
    `FBF_ASSERT_NEXT(a_done_single, clk, rst_n, done_reg, !done_reg, "two results back to back")

endmodule

// ===== hdl/framebuffer_blend_fill_engine_core.sv =====
// 2d drawing engine over a 256x256 rgb frame store that resets to white.
// a request is taken at a rising edge with start high and busy low; it carries
// the command, position, size, colour and alpha in req. every request gives
// exactly one result in rsp, shown for one cycle while done is high; rsp
// holds the pixel for a read, zero colours otherwise; the receiver cannot stall.
// canvas size is set through wr_en / wr_index / wr_data (active width, active
// height); the user must write only while no request is in flight (unchecked).
// the front classifies and clips a request through its registered stages and
// queues it; four requests may wait in the front and queue, beside the one
// being drawn, before busy rises. the back walks the clipped box one pixel per
// cycle through a read-modify-write on the frame memory's read and write ports;
// a fill's box is the whole active canvas. after reset the back sweeps the frame
// store white, one pixel per cycle, with busy high; configuration writes are
// still taken then.
module framebuffer_blend_fill_engine_core
    import fbf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  req_t                 req,
    output logic                 busy,
    output rsp_t                 rsp,
    output logic                 done,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data
);

    logic         accept;
    logic         front_full;
    logic         push;
    desc_t        push_desc;
    logic         pop;
    desc_t        pop_desc;
    q_status_t    q_status;
    back_status_t back_status;

    assign busy   = back_status.clearing || front_full;
    assign accept = start && !busy;

    fbf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req       (req),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .q_status  (q_status),
        .full      (front_full),
        .push      (push),
        .push_desc (push_desc)
    );

    fbf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .pop_desc  (pop_desc),
        .status    (q_status)
    );

    fbf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .pop_desc (pop_desc),
        .pop      (pop),
        .rsp      (rsp),
        .done     (done),
        .status   (back_status)
    );

endmodule
